>>> sv/sine_tone_generator_defines.svh
// Assertion macros for the sine tone generator top level.
`ifndef SINE_TONE_GENERATOR_DEFINES_SVH
`define SINE_TONE_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define STG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define STG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/stg_pkg.sv
// Types, constants and the quarter-wave sine table of the sine tone generator.
package stg_pkg;

  localparam int TABLE_BITS   = 10;
  localparam int PHASE_BITS   = 32;
  localparam int QUARTER_BITS = TABLE_BITS - 2;
  localparam int QUARTER      = 1 << QUARTER_BITS;

  localparam int FREQ_W     = 16;
  localparam int SPH_W      = 40;
  localparam int AMP_W      = 15;
  localparam int MAG_W      = 15;
  localparam int SAMPLE_W   = 16;
  localparam int STEP_SHIFT = 48 - PHASE_BITS;
  localparam int PROD_W     = FREQ_W + SPH_W;
  localparam int SHIFTED_W  = PROD_W - STEP_SHIFT;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 64;

  localparam logic [FREQ_W-1:0] FREQ_LOW  = 16'd16;
  localparam logic [FREQ_W-1:0] FREQ_HIGH = 16'd11025;

  localparam logic [SPH_W-1:0] SPH_RESET = 40'd12765305066;
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd16000;

  localparam logic [63:0] K1 = 64'd1686629713;
  localparam logic [63:0] K3 = 64'd693598668;
  localparam logic [63:0] K5 = 64'd85569306;
  localparam logic [63:0] K7 = 64'd5026995;
  localparam logic [63:0] K9 = 64'd172272;

  typedef enum logic [1:0] {
    CMD_TICK = 2'd0,
    CMD_PLAY = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  typedef enum logic [ADDR_W-1:0] {
    ADDR_STEP_PER_HERTZ = 4'h0,
    ADDR_AMPLITUDE      = 4'h8
  } cfg_addr_t;

  typedef struct packed {
    cmd_t              command;
    logic [FREQ_W-1:0] frequency;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sounding;
  } out_item_t;

  // sin(pi/2 * t), t in Q30 over [0,1], odd degree-9 polynomial, Q0.15 result
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [63:0] t);
    logic [63:0] t2;
    logic [63:0] p;
    logic [63:0] v;
    t2 = (t * t) >> 30;
    p  = K9;
    p  = K7 - ((t2 * p) >> 30);
    p  = K5 - ((t2 * p) >> 30);
    p  = K3 - ((t2 * p) >> 30);
    p  = K1 - ((t2 * p) >> 30);
    p  = (t * p) >> 30;
    v  = (p * 64'd32768 + (64'd1 << 29)) >> 30;
    if (v > 64'd32767) begin
      v = 64'd32767;
    end
    return v[MAG_W-1:0];
  endfunction

  typedef logic [MAG_W-1:0] sine_lut_t [QUARTER];

  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    for (int i = 0; i < QUARTER; i++) begin
      lut[i] = quarter_sine(64'(i) << (30 - QUARTER_BITS));
    end
    return lut;
  endfunction

  localparam sine_lut_t        SINE_LUT  = build_sine_lut();
  localparam logic [MAG_W-1:0] SINE_PEAK = quarter_sine(64'd1 << 30);

endpackage

>>> sv/stg_sine.sv
// Phase to signed sample: quarter-wave table lookup and amplitude scaling.
module stg_sine (
  input  logic [stg_pkg::PHASE_BITS-1:0]   phase,
  input  logic [stg_pkg::AMP_W-1:0]        amplitude,
  output logic signed [stg_pkg::SAMPLE_W-1:0] sample
);
  import stg_pkg::*;

  logic [TABLE_BITS-1:0]   idx;
  logic [1:0]              quadrant;
  logic [QUARTER_BITS-1:0] x;
  logic [QUARTER_BITS-1:0] lut_idx;
  logic [MAG_W-1:0]        mag;
  logic [AMP_W+MAG_W-1:0]  prod;
  logic [SAMPLE_W-1:0]     scaled;

  assign idx      = phase[PHASE_BITS-1 -: TABLE_BITS];
  assign quadrant = idx[TABLE_BITS-1 -: 2];
  assign x        = idx[QUARTER_BITS-1:0];
  assign lut_idx  = quadrant[0] ? (~x + 1'b1) : x;

  always_comb begin
    if (quadrant[0] && (x == '0)) begin
      mag = SINE_PEAK;
    end else begin
      mag = SINE_LUT[lut_idx];
    end
  end

  assign prod   = amplitude * mag;
  assign scaled = {1'b0, prod[AMP_W+MAG_W-1 -: MAG_W]};
  assign sample = quadrant[1] ? $signed(-scaled) : $signed(scaled);

endmodule

>>> sv/sine_tone_generator.sv
// Top level of the phase-accumulator sine tone generator.
//
// Input channel (in_valid / in_stall / in_data) carries commands: tick, play
// with a frequency, stop. Only a tick produces a result on the output channel
// (out_valid / out_stall / out_data): the signed sample and the sounding flag.
// Play and stop transfers update state and return nothing; command 3 is ignored.
// An item accepted into the stage register is worked there, and a tick's result
// is registered in the output register, from which it is offered; a stalled
// tick waits in the stage register. One item per cycle sustained while no held
// result stalls a tick; the stage register feeding the output register sets that
// figure.
// When out_stall holds a result, a waiting tick stays in the stage register and
// in_stall rises; play and stop items still pass through.
// Configuration is an APB-style port: step_per_hertz at 0x0, amplitude at 0x8,
// 64-bit data, pready always high. Write only while the block is idle.
// Synchronous reset clears phase, step and playing, empties both registers and
// loads the configuration defaults.
module sine_tone_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  stg_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output stg_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stg_pkg::ADDR_W-1:0]  paddr,
  input  logic [stg_pkg::DATA_W-1:0]  pwdata,
  output logic [stg_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import stg_pkg::*;

  `include "sine_tone_generator_defines.svh"

  logic [SPH_W-1:0]      sph_r;
  logic [AMP_W-1:0]      amp_r;
  logic [PHASE_BITS-1:0] phase_angle_r, phase_angle_nxt;
  logic [PHASE_BITS-1:0] phase_step_r, phase_step_nxt;
  logic                  playing_r, playing_nxt;
  logic                  s_valid_r, s_valid_nxt;
  in_item_t              s_item_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;

  logic                  cfg_wr;
  logic                  accept;
  logic                  fire;
  logic                  tick_fire;
  logic                  play_ok;
  logic                  wrap;
  logic [PROD_W-1:0]     step_prod;
  logic [SHIFTED_W-1:0]  step_shifted;
  logic [PHASE_BITS-1:0] step_sat;
  logic [PHASE_BITS:0]   phase_sum;
  logic signed [SAMPLE_W-1:0] sample;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_addr_t'(paddr))
      ADDR_STEP_PER_HERTZ: prdata = DATA_W'(sph_r);
      ADDR_AMPLITUDE:      prdata = DATA_W'(amp_r);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sph_r <= SPH_RESET;
      amp_r <= AMP_RESET;
    end else if (cfg_wr) begin
      case (cfg_addr_t'(paddr))
        ADDR_STEP_PER_HERTZ: sph_r <= pwdata[SPH_W-1:0];
        ADDR_AMPLITUDE:      amp_r <= pwdata[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign fire      = s_valid_r && ((s_item_r.command != CMD_TICK) || !out_valid_r || !out_stall);
  assign in_stall  = s_valid_r && !fire;
  assign accept    = in_valid && !in_stall;
  assign tick_fire = fire && (s_item_r.command == CMD_TICK);

  // play: frequency to phase step
  assign play_ok      = (s_item_r.frequency >= FREQ_LOW) && (s_item_r.frequency <= FREQ_HIGH);
  assign step_prod    = s_item_r.frequency * sph_r;
  assign step_shifted = step_prod[PROD_W-1:STEP_SHIFT];
  assign step_sat     = (step_shifted[SHIFTED_W-1:PHASE_BITS] != '0) ? '1
                        : step_shifted[PHASE_BITS-1:0];

  // tick: phase advance
  assign phase_sum = {1'b0, phase_angle_r} + {1'b0, phase_step_r};
  assign wrap      = phase_sum[PHASE_BITS];

  stg_sine u_sine (
    .phase     (phase_angle_r),
    .amplitude (amp_r),
    .sample    (sample)
  );

  always_comb begin
    phase_angle_nxt = phase_angle_r;
    phase_step_nxt  = phase_step_r;
    playing_nxt     = playing_r;
    if (fire) begin
      case (s_item_r.command)
        CMD_PLAY: begin
          playing_nxt = play_ok;
          if (play_ok) begin
            phase_step_nxt = step_sat;
          end
        end
        CMD_STOP: playing_nxt = 1'b0;
        CMD_TICK: begin
          if (wrap && !playing_r) begin
            phase_angle_nxt = '0;
            phase_step_nxt  = '0;
          end else begin
            phase_angle_nxt = phase_sum[PHASE_BITS-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  assign s_valid_nxt   = accept ? 1'b1 : (fire ? 1'b0 : s_valid_r);
  assign out_valid_nxt = tick_fire ? 1'b1 : ((out_valid_r && !out_stall) ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_angle_r <= '0;
      phase_step_r  <= '0;
      playing_r     <= 1'b0;
      s_valid_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_angle_r <= phase_angle_nxt;
      phase_step_r  <= phase_step_nxt;
      playing_r     <= playing_nxt;
      s_valid_r     <= s_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_item_r <= in_data;
    end
    if (tick_fire) begin
      out_item_r.sample   <= sample;
      out_item_r.sounding <= (phase_step_nxt != '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  `STG_ASSERT_NEXT(a_tick_result, tick_fire, out_valid_r, "tick transfer produced no result")
  `STG_ASSERT_SAME(a_empty_no_stall, !s_valid_r, !in_stall, "stall raised with empty stage")
  `STG_ASSERT_NEXT(a_play_marks, fire && (s_item_r.command == CMD_PLAY) && play_ok,
                   playing_r, "in-range play did not set playing")
  `STG_ASSERT_NEXT(a_wrap_silence, tick_fire && wrap && !playing_r,
                   (phase_step_r == '0) && (phase_angle_r == '0), "wrap while stopped kept tone")

endmodule
